// ----- sv/nearest_keyframe_path_table_defines.svh -----
// Assertion macros for the keyframe path table.
// Included by the top level; depends on nothing else.
`ifndef NEAREST_KEYFRAME_PATH_TABLE_DEFINES_SVH
`define NEAREST_KEYFRAME_PATH_TABLE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define NKPT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define NKPT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- sv/nkpt_pkg.sv -----
// Package for the keyframe path table: operation and status codes, states.
// No dependencies.
`timescale 1ns / 1ps
package nkpt_pkg;
    localparam int WORDS = 9;
    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_PREPEND = 3'd1;
    localparam logic [2:0] OP_INSERT  = 3'd2;
    localparam logic [2:0] OP_REMOVE  = 3'd3;
    localparam logic [2:0] OP_REPLACE = 3'd4;
    localparam logic [2:0] OP_CLOSE   = 3'd5;
    localparam logic [2:0] OP_CLEAR   = 3'd6;
    localparam logic [2:0] OP_READ    = 3'd7;
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;
    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_DECIDE = 12'b000000000010,
        S_SRCH_A = 12'b000000000100,
        S_SRCH_D = 12'b000000001000,
        S_SRCH_M = 12'b000000010000,
        S_NEIGH  = 12'b000000100000,
        S_MOVE_R = 12'b000001000000,
        S_MOVE_D = 12'b000010000000,
        S_MOVE_W = 12'b000100000000,
        S_WRITE  = 12'b001000000000,
        S_READ   = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } t_state;
endpackage

// ----- sv/nearest_keyframe_path_table.sv -----
// Top level of the keyframe path table: control sequencer, store, shared unit.
// Depends on nkpt_pkg and nearest_keyframe_path_table_defines.svh.
`timescale 1ns / 1ps
`include "nearest_keyframe_path_table_defines.svh"
// One item is processed at a time; s_axis_tready is high only when idle and
// the result register is empty. The store is a one-port memory of nine words
// per entry; a nearest search reads three eye words per entry through that
// port and a single subtract/square/accumulate unit, stepping through the
// states S_SRCH_A, S_SRCH_D, S_SRCH_M and S_NEIGH for each word (an insert
// may also search the two neighbors of the nearest entry). Insert, prepend
// and remove then move every later entry one word at a time through S_MOVE_R,
// S_MOVE_D and S_MOVE_W, and a keyframe is written one word at a time. A read
// or the fetch of the first entry for close waits in S_READ for each word.
// There is no clearing pass.
module nearest_keyframe_path_table #(
    parameter int MAX_ENTRIES = 64,
    parameter int COORD_BITS  = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // eye_x, eye_y, eye_z, center_x, center_y, center_z, up_x, up_y, up_z,
    // entry_index[293:288], zero fill to 296 bits
    input  logic [295:0] s_axis_tdata,
    // operation
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // read_eye_x .. read_up_z, entry_count[294:288], status[296:295],
    // can_play[297], zero fill to 304 bits
    output logic [303:0] m_axis_tdata
);
    localparam int AW = $clog2(MAX_ENTRIES * nkpt_pkg::WORDS);
    localparam int IW = $clog2(MAX_ENTRIES + 1);
    localparam int DW = 2 * COORD_BITS + 4;
    localparam int DEPTH = MAX_ENTRIES * nkpt_pkg::WORDS;

    logic [COORD_BITS-1:0] r_mem [DEPTH];
    logic [COORD_BITS-1:0] r_rd;
    logic [AW-1:0] r_addr;
    logic r_we;
    logic [COORD_BITS-1:0] r_wd;

    nkpt_pkg::t_state r_state;
    logic [2:0] r_op;
    logic [COORD_BITS-1:0] r_kf [nkpt_pkg::WORDS];
    logic [5:0] r_idx;
    logic [IW-1:0] r_cnt;
    logic [IW-1:0] r_i;      // entry under work
    logic [3:0] r_w;         // word within entry
    logic [IW-1:0] r_best;
    logic [DW-1:0] r_bdist;
    logic [DW-1:0] r_acc;
    logic [DW-1:0] r_prev;
    logic [1:0] r_phase;     // search mode: 0 nearest, 1 prev, 2 next
    logic [IW-1:0] r_pos;
    logic r_dir;             // 1 move toward higher index
    logic [COORD_BITS-1:0] r_sq_a;
    logic [COORD_BITS:0] r_diff;
    logic [1:0] r_status;
    logic [COORD_BITS-1:0] r_out [nkpt_pkg::WORDS];
    logic r_ovalid;

    logic [2*COORD_BITS+1:0] w_sq;
    logic [AW-1:0] w_base;
    function automatic logic [COORD_BITS-1:0] norm(input logic [31:0] v);
        norm = v[COORD_BITS-1:0];
    endfunction
    assign w_sq = $signed(r_diff) * $signed(r_diff);
    assign w_base = AW'(r_i) * AW'(nkpt_pkg::WORDS);

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_addr] <= r_wd;
        r_rd <= r_mem[r_addr];
    end

    assign s_axis_tready = (r_state == nkpt_pkg::S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;

    always_comb begin
        m_axis_tdata = '0;
        for (int k = 0; k < nkpt_pkg::WORDS; k++)
            m_axis_tdata[k*32 +: 32] = 32'($signed(r_out[k]));
        m_axis_tdata[294:288] = 7'(r_cnt);
        m_axis_tdata[296:295] = r_status;
        m_axis_tdata[297] = (r_cnt > IW'(1));
    end

    always_ff @(posedge i_clk) begin
        r_we <= 1'b0;
        if (!i_rst_n) begin
            r_state <= nkpt_pkg::S_IDLE;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                nkpt_pkg::S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op <= s_axis_tuser;
                        for (int k = 0; k < nkpt_pkg::WORDS; k++) begin
                            r_kf[k] <= norm(s_axis_tdata[k*32 +: 32]);
                            r_out[k] <= '0;
                        end
                        r_idx <= s_axis_tdata[293:288];
                        r_status <= nkpt_pkg::ST_DONE;
                        r_state <= nkpt_pkg::S_DECIDE;
                    end
                end
                nkpt_pkg::S_DECIDE: begin
                    r_i <= '0; r_w <= '0; r_phase <= 2'd0;
                    r_best <= '0; r_acc <= '0;
                    r_state <= nkpt_pkg::S_OUT;
                    case (r_op)
                        nkpt_pkg::OP_APPEND, nkpt_pkg::OP_PREPEND,
                        nkpt_pkg::OP_INSERT: begin
                            if (r_cnt >= IW'(MAX_ENTRIES)) begin
                                r_status <= nkpt_pkg::ST_FULL;
                            end else if (r_op == nkpt_pkg::OP_PREPEND) begin
                                r_pos <= '0;
                                r_state <= nkpt_pkg::S_MOVE_R;
                                r_dir <= 1'b1; r_i <= r_cnt - IW'(1);
                            end else if (r_op == nkpt_pkg::OP_APPEND
                                         || r_cnt < IW'(2)) begin
                                r_pos <= r_cnt; r_i <= r_cnt;
                                r_state <= nkpt_pkg::S_WRITE;
                            end else if (r_cnt == IW'(2)) begin
                                r_pos <= IW'(1);
                                r_state <= nkpt_pkg::S_MOVE_R;
                                r_dir <= 1'b1; r_i <= IW'(1);
                            end else begin
                                r_state <= nkpt_pkg::S_SRCH_A;
                            end
                        end
                        nkpt_pkg::OP_REMOVE, nkpt_pkg::OP_REPLACE: begin
                            if (r_cnt == '0) r_status <= nkpt_pkg::ST_IGNORED;
                            else r_state <= nkpt_pkg::S_SRCH_A;
                        end
                        nkpt_pkg::OP_CLOSE: begin
                            if (r_cnt <= IW'(1)) begin
                                r_status <= nkpt_pkg::ST_IGNORED;
                            end else if (r_cnt >= IW'(MAX_ENTRIES)) begin
                                r_status <= nkpt_pkg::ST_FULL;
                            end else begin
                                // Fetch entry 0 into the keyframe buffer first.
                                r_i <= '0; r_w <= '0; r_addr <= '0;
                                r_state <= nkpt_pkg::S_READ;
                            end
                        end
                        nkpt_pkg::OP_CLEAR: r_cnt <= '0;
                        default: begin
                            if (32'(r_idx) >= 32'(r_cnt)) begin
                                r_status <= nkpt_pkg::ST_RANGE;
                            end else begin
                                r_i <= IW'(r_idx); r_w <= '0;
                                r_addr <= AW'(r_idx) * AW'(nkpt_pkg::WORDS);
                                r_state <= nkpt_pkg::S_READ;
                            end
                        end
                    endcase
                end
                nkpt_pkg::S_SRCH_A: begin
                    r_addr <= w_base + AW'(r_w);
                    r_state <= nkpt_pkg::S_SRCH_D;
                end
                nkpt_pkg::S_SRCH_D: begin
                    r_sq_a <= r_kf[r_w];
                    r_state <= nkpt_pkg::S_SRCH_M;
                end
                nkpt_pkg::S_SRCH_M: begin
                    // r_rd is the stored word; diff, then accumulate next pass.
                    r_diff <= $signed({r_sq_a[COORD_BITS-1], r_sq_a})
                            - $signed({r_rd[COORD_BITS-1], r_rd});
                    r_state <= nkpt_pkg::S_NEIGH;
                end
                nkpt_pkg::S_NEIGH: begin
                    logic [DW-1:0] d;
                    d = r_acc + DW'(w_sq);
                    if (r_w != 4'd2) begin
                        r_acc <= d; r_w <= r_w + 4'd1;
                        r_state <= nkpt_pkg::S_SRCH_A;
                    end else begin
                        r_acc <= '0; r_w <= '0;
                        if (r_phase == 2'd0) begin
                            if (r_i == '0 || d < r_bdist) begin
                                r_bdist <= d; r_best <= r_i;
                            end
                            if (r_i + IW'(1) < r_cnt) begin
                                r_i <= r_i + IW'(1);
                                r_state <= nkpt_pkg::S_SRCH_A;
                            end else begin
                                logic [IW-1:0] nb;
                                nb = (r_i == '0 || d < r_bdist) ? r_i : r_best;
                                r_state <= nkpt_pkg::S_MOVE_R;
                                if (r_op == nkpt_pkg::OP_REPLACE) begin
                                    r_i <= nb; r_state <= nkpt_pkg::S_WRITE;
                                end else if (r_op == nkpt_pkg::OP_REMOVE) begin
                                    r_dir <= 1'b0; r_i <= nb + IW'(1);
                                    r_pos <= nb;
                                end else if (nb == '0) begin
                                    r_pos <= IW'(1); r_dir <= 1'b1;
                                    r_i <= r_cnt - IW'(1);
                                end else if (nb == r_cnt - IW'(1)) begin
                                    r_pos <= nb; r_dir <= 1'b1; r_i <= nb;
                                end else begin
                                    r_best <= nb; r_phase <= 2'd1;
                                    r_i <= nb - IW'(1);
                                    r_state <= nkpt_pkg::S_SRCH_A;
                                end
                            end
                        end else if (r_phase == 2'd1) begin
                            r_prev <= d; r_phase <= 2'd2;
                            r_i <= r_best + IW'(1);
                            r_state <= nkpt_pkg::S_SRCH_A;
                        end else begin
                            logic [IW-1:0] p;
                            p = (r_prev < d) ? r_best : r_best + IW'(1);
                            r_pos <= p; r_dir <= 1'b1; r_i <= r_cnt - IW'(1);
                            r_state <= nkpt_pkg::S_MOVE_R;
                        end
                    end
                end
                nkpt_pkg::S_MOVE_R: begin
                    // Up: copy entry r_i to r_i+1 down to r_pos.
                    // Down: copy entry r_i to r_i-1 for r_i from pos+1 to cnt-1.
                    if (r_dir ? (r_i < r_pos || r_i >= r_cnt) : (r_i >= r_cnt)) begin
                        r_w <= '0;
                        if (r_dir) begin
                            r_i <= r_pos; r_state <= nkpt_pkg::S_WRITE;
                        end else begin
                            r_cnt <= r_cnt - IW'(1); r_state <= nkpt_pkg::S_OUT;
                        end
                    end else begin
                        r_addr <= w_base + AW'(r_w);
                        r_state <= nkpt_pkg::S_MOVE_D;
                    end
                end
                nkpt_pkg::S_MOVE_D: begin
                    // The memory registers the source word during this cycle.
                    r_state <= nkpt_pkg::S_MOVE_W;
                end
                nkpt_pkg::S_MOVE_W: begin
                    r_we <= 1'b1; r_wd <= r_rd;
                    r_addr <= r_dir ? w_base + AW'(nkpt_pkg::WORDS) + AW'(r_w)
                                    : w_base - AW'(nkpt_pkg::WORDS) + AW'(r_w);
                    r_state <= nkpt_pkg::S_MOVE_R;
                    if (r_w == 4'(nkpt_pkg::WORDS - 1)) begin
                        r_w <= '0;
                        if (r_dir) begin
                            if (r_i == r_pos) r_i <= r_cnt; // done marker
                            else r_i <= r_i - IW'(1);
                        end else begin
                            r_i <= r_i + IW'(1);
                        end
                    end else begin
                        r_w <= r_w + 4'd1;
                    end
                end
                nkpt_pkg::S_WRITE: begin
                    r_we <= 1'b1; r_wd <= r_kf[r_w];
                    r_addr <= w_base + AW'(r_w);
                    if (r_w == 4'(nkpt_pkg::WORDS - 1)) begin
                        if (r_op != nkpt_pkg::OP_REPLACE) r_cnt <= r_cnt + IW'(1);
                        r_state <= nkpt_pkg::S_OUT;
                    end else begin
                        r_w <= r_w + 4'd1;
                    end
                end
                nkpt_pkg::S_READ: begin
                    // Address issued in the previous cycle; the word is taken when r_phase reaches 2.
                    r_phase <= r_phase + 2'd1;
                    if (r_phase == 2'd2) begin
                        r_phase <= 2'd0;
                        if (r_op == nkpt_pkg::OP_CLOSE) r_kf[r_w] <= r_rd;
                        else r_out[r_w] <= r_rd;
                        if (r_w == 4'(nkpt_pkg::WORDS - 1)) begin
                            r_w <= '0;
                            if (r_op == nkpt_pkg::OP_CLOSE) begin
                                r_i <= r_cnt; r_state <= nkpt_pkg::S_WRITE;
                            end else begin
                                r_state <= nkpt_pkg::S_OUT;
                            end
                        end else begin
                            r_w <= r_w + 4'd1;
                            r_addr <= w_base + AW'(r_w) + AW'(1);
                        end
                    end
                end
                nkpt_pkg::S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= nkpt_pkg::S_IDLE;
                end
                default: r_state <= nkpt_pkg::S_IDLE;
            endcase
        end
    end

    `NKPT_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= IW'(MAX_ENTRIES))
    `NKPT_ASSERT_NXT(a_out_once, i_clk, i_rst_n, r_state == nkpt_pkg::S_OUT, r_ovalid)
    `NKPT_ASSERT_IMP(a_busy_no_ready, i_clk, i_rst_n, r_state != nkpt_pkg::S_IDLE, !s_axis_tready)
endmodule

// ----- verif/nkpt_checker.sv -----
// Checker for the keyframe path table: watches both streams, predicts each result.
// Depends on nkpt_pkg.
`timescale 1ns / 1ps
module nkpt_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [295:0] s_axis_tdata,
    input  logic [2:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [303:0] m_axis_tdata,
    output int           o_errors,
    output int           o_pending
);
    localparam int MAX_KF = 64;

    typedef logic signed [31:0] t_coord;
    typedef t_coord t_kf [nkpt_pkg::WORDS];

    t_kf               path_model [MAX_KF];
    int                kf_count;
    logic [303:0]      expected_results [16];
    logic [3:0]        wr_ptr, rd_ptr;
    int                pending;

    assign o_pending = pending;

    function automatic logic [66:0] eye_dist(t_kf a, t_kf b);
        logic [66:0] acc;
        logic signed [33:0] d;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            d = 34'(a[k]) - 34'(b[k]);
            acc += 67'(d * d);
        end
        return acc;
    endfunction

    function automatic int nearest_of(t_kf kf);
        int best;
        logic [66:0] bd, cd;
        best = 0;
        bd = eye_dist(kf, path_model[0]);
        for (int i = 1; i < kf_count; i++) begin
            cd = eye_dist(kf, path_model[i]);
            if (cd < bd) begin
                bd = cd;
                best = i;
            end
        end
        return best;
    endfunction

    function automatic void put_at(int pos, t_kf kf);
        for (int i = kf_count; i > pos; i--) path_model[i] = path_model[i-1];
        path_model[pos] = kf;
        kf_count++;
    endfunction

    function automatic int insert_slot(t_kf kf);
        int n;
        if (kf_count < 2) return kf_count;
        if (kf_count == 2) return 1;
        n = nearest_of(kf);
        if (n == 0) return 1;
        if (n == kf_count - 1) return n;
        // Ties between the two neighbors place the new keyframe after the nearest.
        return (eye_dist(kf, path_model[n-1]) < eye_dist(kf, path_model[n+1])) ? n : n + 1;
    endfunction

    function automatic logic [303:0] predict_result(logic [2:0] op, logic [295:0] data);
        t_kf kf;
        int n, idx;
        logic [1:0] status;
        logic [303:0] res;
        res = '0;
        status = nkpt_pkg::ST_DONE;
        for (int k = 0; k < nkpt_pkg::WORDS; k++) kf[k] = data[32*k +: 32];
        idx = int'(data[293:288]);
        case (op)
            nkpt_pkg::OP_APPEND, nkpt_pkg::OP_PREPEND, nkpt_pkg::OP_INSERT: begin
                if (kf_count >= MAX_KF) status = nkpt_pkg::ST_FULL;
                else if (op == nkpt_pkg::OP_APPEND) put_at(kf_count, kf);
                else if (op == nkpt_pkg::OP_PREPEND) put_at(0, kf);
                else put_at(insert_slot(kf), kf);
            end
            nkpt_pkg::OP_REMOVE: begin
                if (kf_count == 0) status = nkpt_pkg::ST_IGNORED;
                else begin
                    n = nearest_of(kf);
                    for (int i = n; i < kf_count - 1; i++) path_model[i] = path_model[i+1];
                    kf_count--;
                end
            end
            nkpt_pkg::OP_REPLACE: begin
                if (kf_count == 0) status = nkpt_pkg::ST_IGNORED;
                else path_model[nearest_of(kf)] = kf;
            end
            nkpt_pkg::OP_CLOSE: begin
                if (kf_count <= 1) status = nkpt_pkg::ST_IGNORED;
                else if (kf_count >= MAX_KF) status = nkpt_pkg::ST_FULL;
                else put_at(kf_count, path_model[0]);
            end
            nkpt_pkg::OP_CLEAR: kf_count = 0;
            default: begin
                if (idx >= kf_count) status = nkpt_pkg::ST_RANGE;
                else for (int k = 0; k < nkpt_pkg::WORDS; k++)
                    res[32*k +: 32] = path_model[idx][k];
            end
        endcase
        res[294:288] = 7'(kf_count);
        res[296:295] = status;
        res[297] = kf_count > 1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        logic [303:0] want;
        logic in_acc, out_acc;
        if (!i_rst_n) begin
            kf_count = 0;
            o_errors <= 0;
            wr_ptr <= '0;
            rd_ptr <= '0;
            pending <= 0;
        end else begin
            in_acc = s_axis_tvalid && s_axis_tready;
            out_acc = m_axis_tvalid && m_axis_tready;
            if (in_acc) begin
                expected_results[wr_ptr] <= predict_result(s_axis_tuser, s_axis_tdata);
                wr_ptr <= wr_ptr + 4'd1;
            end
            if (out_acc) begin
                if (pending == 0) begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results[rd_ptr];
                    rd_ptr <= rd_ptr + 4'd1;
                    for (int k = 0; k < nkpt_pkg::WORDS; k++)
                        if (want[32*k +: 32] !== m_axis_tdata[32*k +: 32])
                            $display("%0t: coord %0d expected %h actual %h", $time, k,
                                     want[32*k +: 32], m_axis_tdata[32*k +: 32]);
                    if (want[294:288] !== m_axis_tdata[294:288])
                        $display("%0t: entry_count expected %0d actual %0d", $time,
                                 want[294:288], m_axis_tdata[294:288]);
                    if (want[296:295] !== m_axis_tdata[296:295])
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want[296:295], m_axis_tdata[296:295]);
                    if (want[297] !== m_axis_tdata[297])
                        $display("%0t: can_play expected %0d actual %0d", $time,
                                 want[297], m_axis_tdata[297]);
                    if (want[297:0] !== m_axis_tdata[297:0]) o_errors <= o_errors + 1;
                end
            end
            pending <= pending + (in_acc ? 1 : 0) - ((out_acc && pending != 0) ? 1 : 0);
        end
    end
endmodule

// ----- verif/tb_nearest_keyframe_path_table.sv -----
// Testbench top for the keyframe path table: clock, reset, stimulus, verdict.
// Depends on nkpt_pkg, nkpt_checker and the block itself.
`timescale 1ns / 1ps
module tb_nearest_keyframe_path_table;
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [295:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = nkpt_pkg::OP_CLEAR;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [303:0] m_axis_tdata;
    int           error_count, pending_count;
    logic         stall_free = 1'b0;
    logic [31:0]  eye_pool [8];

    always #5 i_clk = ~i_clk;

    nearest_keyframe_path_table dut (.*);

    nkpt_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_errors(error_count), .o_pending(pending_count)
    );

    // Receiver stalls: ready dropped at random, with stall-free phases.
    always @(posedge i_clk) begin
        if (stall_free) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 400) == 0) stall_free <= ~stall_free;
    end

    initial begin
        #200ms;
        $display("status: fail");
        $finish;
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return eye_pool[3'($urandom_range(0, 7))];
            3: return $urandom_range(0, 8) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [2:0] op, logic [295:0] data);
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random(logic [2:0] op, bit extreme);
        logic [295:0] d;
        d = '0;
        for (int k = 0; k < nkpt_pkg::WORDS; k++)
            d[32*k +: 32] = extreme ? (k[0] ? 32'h8000_0000 : 32'h7fff_ffff) : rand_coord();
        d[293:288] = 6'($urandom_range(0, 63));
        send_item(op, d);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    initial begin
        logic [2:0] op;
        int burst, sel;
        for (int k = 0; k < 8; k++) eye_pool[k] = $urandom;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-table cases, extremes, each operation, ties.
        send_random(nkpt_pkg::OP_REMOVE, 0);
        send_random(nkpt_pkg::OP_REPLACE, 0);
        send_random(nkpt_pkg::OP_CLOSE, 0);
        send_random(nkpt_pkg::OP_READ, 0);
        send_random(nkpt_pkg::OP_APPEND, 1);
        send_random(nkpt_pkg::OP_CLOSE, 0);
        send_random(nkpt_pkg::OP_PREPEND, 0);
        send_random(nkpt_pkg::OP_INSERT, 1);
        send_random(nkpt_pkg::OP_INSERT, 0);
        send_random(nkpt_pkg::OP_INSERT, 1);
        send_random(nkpt_pkg::OP_CLOSE, 0);
        for (int i = 0; i < 8; i++) begin
            pause_sender();
            send_item(nkpt_pkg::OP_READ, {2'b0, 6'(i), 288'b0});
        end
        send_random(nkpt_pkg::OP_REPLACE, 1);
        send_random(nkpt_pkg::OP_REMOVE, 1);
        send_item(nkpt_pkg::OP_READ, {2'b0, 6'h3f, 288'b0});
        send_random(nkpt_pkg::OP_CLEAR, 0);

        // Random bursts; a fill-to-full run when a burst starts at 50 modulo 100 items, so the full cases hit.
        for (int n = 0; n < 500;) begin
            if (n % 100 == 50) begin
                for (int i = 0; i < 66; i++) send_random(nkpt_pkg::OP_APPEND, 0);
                send_random(nkpt_pkg::OP_CLOSE, 0);
                send_random(nkpt_pkg::OP_INSERT, 0);
                send_random(nkpt_pkg::OP_PREPEND, 0);
                send_item(nkpt_pkg::OP_READ, {2'b0, 6'h3f, 288'b0});
                n += 70;
            end
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                sel = $urandom_range(0, 99);
                if (sel < 25) op = nkpt_pkg::OP_INSERT;
                else if (sel < 40) op = nkpt_pkg::OP_APPEND;
                else if (sel < 47) op = nkpt_pkg::OP_PREPEND;
                else if (sel < 60) op = nkpt_pkg::OP_REMOVE;
                else if (sel < 70) op = nkpt_pkg::OP_REPLACE;
                else if (sel < 75) op = nkpt_pkg::OP_CLOSE;
                else if (sel < 77) op = nkpt_pkg::OP_CLEAR;
                else op = nkpt_pkg::OP_READ;
                send_random(op, 0);
                n++;
            end
            if ($urandom_range(0, 2) != 0) pause_sender();
        end
        s_axis_tvalid <= 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
